FILE: hw/rtl/tbt_pkg.sv
// trickle beacon timer package: command and result types, codes, sizes
// used by every module of the block; no dependencies
package tbt_pkg;

    localparam int COUNT_BITS  = 8;
    localparam int THR_BITS    = 8;
    localparam int CMP_W       = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
    localparam int IVL_BITS    = 31;
    localparam int TIME_BITS   = 32;
    localparam int DIV_STEPS   = TIME_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_RESET = 3'd3;
    localparam logic [2:0] REQ_HEARD = 3'd4;
    localparam logic [2:0] REQ_SENT  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR = 2'd2;

    localparam logic [IVL_BITS-1:0] IVL_MIN_RST = 31'd1000;
    localparam logic [IVL_BITS-1:0] IVL_MAX_RST = 31'd60000;
    localparam logic [THR_BITS-1:0] THR_RST     = 8'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_RESET,
        OP_HEARD,
        OP_SENT
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] rnd;
    } cmd_t;

    typedef struct packed {
        logic [IVL_BITS-1:0] ivl_lo;
        logic [IVL_BITS-1:0] ivl_hi;
        logic [THR_BITS-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic                 running;
        logic                 suppressed;
        logic [IVL_BITS-1:0]  interval_now;
        logic [TIME_BITS-1:0] time_to_beacon;
        logic                 beacon_due;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OPEN,
        ST_WAIT,
        ST_FINISH,
        ST_REPORT
    } back_state_t;

endpackage

FILE: hw/rtl/tbt_front.sv
// front stage: takes events from the input stream and decodes them to commands
// depends on tbt_pkg
module tbt_front import tbt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // now, consistent flag, random_word, zero fill
    input  logic [2:0]  s_tuser,   // req_type
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_ready
);

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    always_comb begin
        cmd_next.now = s_tdata[31:0];
        cmd_next.rnd = s_tdata[64:33];
        case (s_tuser)
            REQ_TICK:  cmd_next.op = OP_TICK;
            REQ_START: cmd_next.op = OP_START;
            REQ_STOP:  cmd_next.op = OP_STOP;
            REQ_RESET: cmd_next.op = OP_RESET;
            REQ_HEARD: cmd_next.op = s_tdata[32] ? OP_HEARD : OP_NOP;
            REQ_SENT:  cmd_next.op = OP_SENT;
            default:   cmd_next.op = OP_NOP;
        endcase
    end

    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;
    assign push     = valid_reg && q_ready;
    assign push_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: hw/rtl/tbt_fifo.sv
// short command queue between the front and back stages
// depends on tbt_pkg
module tbt_fifo import tbt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_ready,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue written while full");
`endif

endmodule

FILE: hw/rtl/tbt_mod.sv
// iterative remainder unit, one quotient bit per cycle
// depends on tbt_pkg
module tbt_mod import tbt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [IVL_BITS-1:0]  divisor,
    output mod_stat_t            stat,
    output logic [IVL_BITS-1:0]  remainder
);

    logic [IVL_BITS-1:0]  rem_reg;
    logic [TIME_BITS-1:0] shift_reg;
    logic [IVL_BITS-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [TIME_BITS-1:0] trial;
    logic [TIME_BITS-1:0] diff;
    logic                 fits;

    assign trial = {rem_reg, shift_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            shift_reg <= dividend;
            dsr_reg   <= divisor;
            zero_reg  <= divisor == '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[TIME_BITS-2:0], 1'b0};
            rem_reg   <= fits ? diff[IVL_BITS-1:0] : trial[IVL_BITS-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = zero_reg ? '0 : rem_reg;

endmodule

FILE: hw/rtl/tbt_back.sv
// back stage: trickle state, event execution and the result register
// depends on tbt_pkg and tbt_mod
module tbt_back import tbt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cmd_reg;
    logic                 active_reg;
    logic [IVL_BITS-1:0]  interval_reg;
    logic [TIME_BITS-1:0] begin_reg;
    logic [TIME_BITS-1:0] beacon_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                 sup_reg;
    logic [TIME_BITS-1:0] base_reg;
    logic                 m_valid_reg;
    result_t              out_reg;

    logic                 mod_start;
    logic                 out_load;
    mod_stat_t            mod_stat;
    logic [IVL_BITS-1:0]  mod_rem;

    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;
    logic [TIME_BITS-1:0] doubled;
    logic [IVL_BITS-1:0]  capped;
    logic                 go_open;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [IVL_BITS-2:0]  half;
    logic [IVL_BITS-1:0]  span;
    logic [TIME_BITS-1:0] to_beacon;
    logic                 reached;
    result_t              res;

    assign elapsed = cmd_reg.now - begin_reg;
    assign expired = active_reg && (elapsed >= {1'b0, interval_reg});
    assign doubled = {interval_reg, 1'b0};
    assign capped  = (doubled > {1'b0, cfg.ivl_hi}) ? cfg.ivl_hi
                                                     : doubled[IVL_BITS-1:0];
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign half    = interval_reg[IVL_BITS-1:1];
    assign span    = interval_reg - {1'b0, half};

    always_comb begin
        case (cmd_reg.op)
            OP_TICK:  go_open = expired;
            OP_START: go_open = 1'b1;
            OP_RESET: go_open = active_reg;
            default:  go_open = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_EXEC;
            ST_EXEC:   state_next = go_open ? ST_OPEN : ST_REPORT;
            ST_OPEN:   state_next = ST_WAIT;
            ST_WAIT:   if (mod_stat.done) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_REPORT;
            ST_REPORT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        mod_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   pop = q_valid;
            ST_OPEN:   mod_start = 1'b1;
            ST_REPORT: out_load = !m_valid_reg || m_ready;
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign to_beacon = beacon_reg - cmd_reg.now;
    assign reached   = (to_beacon == '0) || to_beacon[TIME_BITS-1];

    always_comb begin
        res.running        = active_reg;
        res.suppressed     = sup_reg;
        res.interval_now   = interval_reg;
        res.beacon_due     = active_reg && reached && !sup_reg;
        if (!active_reg) begin
            res.time_to_beacon = '1;
        end else if (reached) begin
            res.time_to_beacon = '0;
        end else begin
            res.time_to_beacon = to_beacon;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            interval_reg <= IVL_MIN_RST;
            begin_reg    <= '0;
            beacon_reg   <= '0;
            cnt_reg      <= '0;
            sup_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_EXEC: begin
                    case (cmd_reg.op)
                        OP_TICK: if (expired) interval_reg <= capped;
                        OP_START: begin
                            interval_reg <= cfg.ivl_lo;
                            active_reg   <= 1'b1;
                        end
                        OP_STOP: active_reg <= 1'b0;
                        OP_RESET: if (active_reg) interval_reg <= cfg.ivl_lo;
                        OP_HEARD: begin
                            if (active_reg) begin
                                cnt_reg <= cnt_inc;
                                if (CMP_W'(cnt_inc) >= CMP_W'(cfg.threshold)) begin
                                    sup_reg <= 1'b1;
                                end
                            end
                        end
                        OP_SENT: beacon_reg <= begin_reg + {1'b0, interval_reg};
                        default: begin
                            sup_reg <= sup_reg;
                        end
                    endcase
                end
                ST_FINISH: begin
                    begin_reg  <= cmd_reg.now;
                    cnt_reg    <= '0;
                    sup_reg    <= 1'b0;
                    beacon_reg <= base_reg + {1'b0, mod_rem};
                end
                default: begin
                    sup_reg <= sup_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= q_cmd;
        end
        if (mod_start) begin
            base_reg <= cmd_reg.now + {2'b00, half};
        end
        if (out_load) begin
            out_reg <= res;
        end
    end

    tbt_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (cmd_reg.rnd),
        .divisor   (span),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

`ifndef SYNTHESIS
    a_mod_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_start |-> !mod_stat.busy)
        else $error("remainder unit restarted while busy");
    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.running) |->
            (out_reg.time_to_beacon == '1) && !out_reg.beacon_due)
        else $error("inactive result reports a beacon");
    a_interval_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |=> (cnt_reg == '0) && !sup_reg &&
            (begin_reg == $past(cmd_reg.now)))
        else $error("new interval not opened cleanly");
`endif

endmodule

FILE: hw/rtl/trickle_beacon_timer.sv
// trickle beacon timer top level: config registers, front, queue and back stages
// events that open a new interval (start, reset while running, expiring tick) also
// pass through the one-bit-per-cycle remainder unit that places the beacon; the
// back stage finishes one event before it pops the next, while the front and the
// queue keep taking events until both are full
// reset: aresetn synchronous active low, clears all but data regs, no clearing pass
module trickle_beacon_timer import tbt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // now, consistent flag, random_word, zero fill
    input  logic [2:0]           s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // beacon_due, time_to_beacon, interval_now,
                                            // suppressed, running, zero fill
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IVL_BITS-1:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    logic    push;
    cmd_t    push_cmd;
    logic    q_ready;
    logic    q_valid;
    cmd_t    q_cmd;
    logic    pop;
    result_t m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ivl_lo    <= IVL_MIN_RST;
            cfg_reg.ivl_hi    <= IVL_MAX_RST;
            cfg_reg.threshold <= THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_MIN: cfg_reg.ivl_lo    <= cfg_wdata;
                CFG_IDX_MAX: cfg_reg.ivl_hi    <= cfg_wdata;
                CFG_IDX_THR: cfg_reg.threshold <= cfg_wdata[THR_BITS-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    tbt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    tbt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tbt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {6'b000000, m_result};

endmodule

FILE: tb/trickle_beacon_timer_tb.sv
// testbench for trickle_beacon_timer: directed and random event streams on the input
// channel, each result word checked against an in-bench trickle timer predictor
// depends on tbt_pkg and the trickle_beacon_timer rtl
module trickle_beacon_timer_tb import tbt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now;
        logic        consistent;
        logic [31:0] rnd;
    } trickle_evt_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;   // now, consistent flag, random_word, zero fill
    logic [2:0]           s_tuser = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [71:0]          m_tdata;        // beacon_due, time_to_beacon, interval_now,
                                          // suppressed, running, zero fill
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IVL_BITS-1:0]  cfg_wdata = '0;

    trickle_beacon_timer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // predictor copy of registers and timer state
    logic [IVL_BITS-1:0]   pred_min = IVL_MIN_RST;
    logic [IVL_BITS-1:0]   pred_max = IVL_MAX_RST;
    logic [THR_BITS-1:0]   pred_thr = THR_RST;
    logic                  pred_active = 1'b0;
    logic [IVL_BITS-1:0]   pred_ivl = IVL_MIN_RST;
    logic [31:0]           pred_begin = '0;
    logic [31:0]           pred_beacon = '0;
    logic [COUNT_BITS-1:0] pred_heard = '0;
    logic                  pred_supp = 1'b0;

    trickle_evt_t pending_events[$];
    result_t      expected_reports[$];
    trickle_evt_t drv_evt;

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    bit          word_taken = 1'b0;
    int          quiet_cycles = 0;
    int          fail_count = 0;
    int          events_sent = 0;
    int          reports_checked = 0;
    int          beacons_due = 0;
    int          suppressed_seen = 0;

    function automatic void open_window(logic [31:0] now, logic [31:0] rnd);
        logic [31:0] half;
        logic [31:0] span;
        logic [31:0] offset;
        half = {1'b0, pred_ivl} >> 1;
        span = {1'b0, pred_ivl} - half;
        offset = (span != 0) ? half + (rnd % span) : half;
        pred_begin = now;
        pred_heard = '0;
        pred_supp = 1'b0;
        pred_beacon = now + offset;
    endfunction

    function automatic result_t trickle_advance(trickle_evt_t e);
        result_t     r;
        logic [31:0] doubled;
        logic [31:0] gap;
        logic        reached;
        case (e.kind)
            REQ_TICK: begin
                if (pred_active && (e.now - pred_begin) >= {1'b0, pred_ivl}) begin
                    doubled = {1'b0, pred_ivl} << 1;
                    if (doubled > {1'b0, pred_max})
                        doubled = {1'b0, pred_max};
                    pred_ivl = doubled[IVL_BITS-1:0];
                    open_window(e.now, e.rnd);
                end
            end
            REQ_START: begin
                pred_ivl = pred_min;
                pred_active = 1'b1;
                open_window(e.now, e.rnd);
            end
            REQ_STOP: pred_active = 1'b0;
            REQ_RESET: begin
                if (pred_active) begin
                    pred_ivl = pred_min;
                    open_window(e.now, e.rnd);
                end
            end
            REQ_HEARD: begin
                if (pred_active && e.consistent) begin
                    if (pred_heard != COUNT_MAX)
                        pred_heard = pred_heard + 1'b1;
                    if (32'(pred_heard) >= 32'(pred_thr))
                        pred_supp = 1'b1;
                end
            end
            REQ_SENT: pred_beacon = pred_begin + {1'b0, pred_ivl};
            default: ;
        endcase
        gap = pred_beacon - e.now;
        reached = (gap == 0) || gap[31];
        r.beacon_due = pred_active && reached && !pred_supp;
        r.time_to_beacon = !pred_active ? 32'hFFFF_FFFF : (reached ? 32'd0 : gap);
        r.interval_now = pred_ivl;
        r.suppressed = pred_supp;
        r.running = pred_active;
        return r;
    endfunction

    task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver: input word and result back-pressure change on the falling edge
    always @(negedge aclk) begin
        if (!s_tvalid || word_taken) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_evt = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'b0, drv_evt.rnd, drv_evt.consistent, drv_evt.now};
                s_tuser <= drv_evt.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        bit      out_taken;
        word_taken = aresetn && s_tvalid && s_tready;
        out_taken = aresetn && m_tvalid && m_tready;
        if (out_taken) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_reports.size() == 0) begin
                $error("result word 0x%0h with no event waiting for it", got);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                match_field("beacon_due", want.beacon_due, got.beacon_due);
                match_field("time_to_beacon", want.time_to_beacon, got.time_to_beacon);
                match_field("interval_now", want.interval_now, got.interval_now);
                match_field("suppressed", want.suppressed, got.suppressed);
                match_field("running", want.running, got.running);
                reports_checked++;
                beacons_due += want.beacon_due;
                suppressed_seen += want.suppressed;
            end
        end
        if (word_taken) begin
            expected_reports.push_back(trickle_advance(drv_evt));
            events_sent++;
        end
        quiet_cycles = (word_taken || out_taken) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void add_evt(logic [2:0] kind, logic [31:0] now, logic cons,
                                    logic [31:0] rnd);
        trickle_evt_t e;
        e.kind = kind;
        e.now = now;
        e.consistent = cons;
        e.rnd = rnd;
        pending_events.push_back(e);
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IVL_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_IDX_MIN: pred_min = value;
            CFG_IDX_MAX: pred_max = value;
            CFG_IDX_THR: pred_thr = value[THR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed sessions with advancing time, some noise words
    task automatic queue_traffic(int count, bit sat_burst);
        int          made;
        logic [31:0] t;
        logic [31:0] lo_span;
        logic [31:0] hi_span;
        logic [2:0]  kind;
        int unsigned pick;
        made = 1;
        t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(5000) : $urandom();
        lo_span = (pred_min < 4) ? 32'd4 : {1'b0, pred_min};
        hi_span = (pred_max > pred_min) ? {1'b0, pred_max} : {1'b0, pred_min};
        if (hi_span < 4)
            hi_span = 4;
        add_evt(REQ_START, t, 1'($urandom), random_word());
        if (sat_burst) begin
            repeat (260) add_evt(REQ_HEARD, t, 1'b1, random_word());
            made += 260;
        end
        while (made < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: t += $urandom_range(0, lo_span);
                4, 5, 6: t += $urandom_range(0, hi_span);
                7: ;
                8: t += $urandom_range(0, hi_span << 1);
                default: t += $urandom();
            endcase
            pick = $urandom_range(99);
            if (pick < 38) kind = REQ_TICK;
            else if (pick < 62) kind = REQ_HEARD;
            else if (pick < 70) kind = REQ_SENT;
            else if (pick < 76) kind = REQ_RESET;
            else if (pick < 81) kind = REQ_START;
            else if (pick < 85) kind = REQ_STOP;
            else if (pick < 90) kind = 3'($urandom_range(7));
            else kind = 3'bx;
            if (kind === 3'bx)
                add_evt(3'($urandom_range(7)), $urandom(), 1'($urandom), random_word());
            else if (kind == REQ_HEARD && $urandom_range(49) == 0) begin
                repeat ($urandom_range(5, 20)) begin
                    add_evt(REQ_HEARD, t, 1'($urandom_range(9) < 8), random_word());
                    made++;
                end
            end else
                add_evt(kind, t, 1'($urandom_range(9) < 8), random_word());
            made++;
        end
    endtask

    initial begin : stimulus
        logic [IVL_BITS-1:0] ph_min[6];
        logic [IVL_BITS-1:0] ph_max[6];
        logic [THR_BITS-1:0] ph_thr[6];
        int unsigned         idle_src[4];
        int unsigned         idle_snk[4];
        ph_min = '{IVL_MIN_RST, 31'd1, 31'd100, 31'd0, 31'h7FFF_FFFF, 31'd3};
        ph_max = '{IVL_MAX_RST, 31'd16, 31'd40, 31'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
        ph_thr = '{THR_RST, 8'd0, 8'd255, 8'd1, 8'd2, 8'd5};
        idle_src = '{0, 46, 0, 28};
        idle_snk = '{0, 0, 46, 28};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values, inactive events, suppression, expiry, wrap of time
        add_evt(REQ_TICK, 32'd5, 1'b0, 32'd0);
        add_evt(REQ_HEARD, 32'd6, 1'b1, 32'd0);
        add_evt(REQ_RESET, 32'd7, 1'b0, 32'd0);
        add_evt(REQ_SENT, 32'd8, 1'b0, 32'd0);
        add_evt(REQ_START, 32'd100, 1'b0, 32'd0);
        add_evt(REQ_TICK, 32'd200, 1'b0, 32'd7);
        add_evt(REQ_HEARD, 32'd300, 1'b0, 32'd0);
        repeat (3) add_evt(REQ_HEARD, 32'd400, 1'b1, 32'd0);
        add_evt(REQ_TICK, 32'd1100, 1'b0, 32'hFFFF_FFFF);
        add_evt(REQ_SENT, 32'd1200, 1'b0, 32'd0);
        add_evt(REQ_TICK, 32'd3100, 1'b1, 32'h5555_AAAA);
        add_evt(REQ_START, 32'd3200, 1'b0, 32'd12345);
        add_evt(REQ_RESET, 32'd3300, 1'b0, 32'hFFFF_FFFF);
        add_evt(REQ_SPARE6, 32'd3400, 1'b1, 32'hFFFF_FFFF);
        add_evt(REQ_SPARE7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_evt(REQ_STOP, 32'd3500, 1'b0, 32'd0);
        add_evt(REQ_START, 32'hFFFF_FF00, 1'b0, 32'h8000_0000);
        add_evt(REQ_TICK, 32'h0000_00F0, 1'b0, 32'd1);
        add_evt(REQ_TICK, 32'h0000_0400, 1'b0, 32'hAAAA_5555);
        add_evt(REQ_HEARD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_evt(REQ_STOP, 32'd0, 1'b0, 32'd0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(CFG_IDX_MIN, ph_min[ph]);
                write_reg(CFG_IDX_MAX, ph_max[ph]);
                write_reg(CFG_IDX_THR, {23'd0, ph_thr[ph]});
                @(negedge aclk);
                cfg_wr_en <= 1'b0;
            end
            src_idle_pct = idle_src[ph % 4];
            snk_stall_pct = idle_snk[ph % 4];
            queue_traffic((ph == 0) ? 250 : 270, ph == 2);
        end
        drain();

        $display("%0d events over six register settings and four flow-control mixes,",
                 events_sent);
        $display("%0d result words checked, %0d with beacon due, %0d suppressed",
                 reports_checked, beacons_due, suppressed_seen);
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: trickle_beacon_timer.f
hw/rtl/tbt_pkg.sv
hw/rtl/tbt_front.sv
hw/rtl/tbt_fifo.sv
hw/rtl/tbt_mod.sv
hw/rtl/tbt_back.sv
hw/rtl/trickle_beacon_timer.sv
tb/trickle_beacon_timer_tb.sv
